// File: sv/hsatd_pkg.sv
// hsatd_pkg: shared types, constants and transform helpers for the hadamard satd block
// no dependencies; imported by every hsatd module
package hsatd_pkg;

	localparam int NUM_LANES = 4;

	localparam logic MODE_8X4   = 1'b0;
	localparam logic MODE_16X16 = 1'b1;

	localparam logic [1:0] LAST_ROW    = 2'd3;
	localparam logic [5:0] LAST_POS_16 = 6'd63;
	localparam logic [5:0] LAST_POS_8  = 6'd7;
	localparam logic [18:0] SATD_MAX   = 19'd522240;

	typedef logic signed [10:0] rowc_t;
	typedef logic signed [12:0] coef_t;
	typedef logic [11:0] absc_t;
	typedef logic [13:0] lsum_t;
	typedef logic [16:0] sub_t;
	typedef logic [19:0] total_t;

	typedef struct packed {
		coef_t c0;
		coef_t c1;
		coef_t c2;
		coef_t c3;
	} quad_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		logic [1:0] seg;
		logic       last;
	} ctrl_t;

	function automatic quad_t had4(quad_t s);
		coef_t t0;
		coef_t t1;
		coef_t t2;
		coef_t t3;
		quad_t d;
		t0 = s.c0 + s.c1;
		t1 = s.c0 - s.c1;
		t2 = s.c2 + s.c3;
		t3 = s.c2 - s.c3;
		d.c0 = t0 + t2;
		d.c1 = t1 + t3;
		d.c2 = t0 - t2;
		d.c3 = t1 - t3;
		return d;
	endfunction

	function automatic absc_t abs_coef(coef_t c);
		coef_t m;
		m = (c < 0) ? -c : c;
		return m[11:0];
	endfunction

endpackage

// File: sv/hsatd_row_xform.sv
// hsatd_row_xform: pixel differences and 4-point row hadamard, stage 1
// depends on hsatd_pkg
module hsatd_row_xform import hsatd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctrl_t            ctrl_in,
	input  logic [3:0][7:0]  src_row,
	input  logic [3:0][7:0]  ref_row,
	output ctrl_t            ctrl_s1,
	output rowc_t            rowc_s1 [NUM_LANES]
);

	quad_t diff;
	quad_t rc;

	always_comb begin
		diff.c0 = coef_t'($signed({1'b0, src_row[0]})) - coef_t'($signed({1'b0, ref_row[0]}));
		diff.c1 = coef_t'($signed({1'b0, src_row[1]})) - coef_t'($signed({1'b0, ref_row[1]}));
		diff.c2 = coef_t'($signed({1'b0, src_row[2]})) - coef_t'($signed({1'b0, ref_row[2]}));
		diff.c3 = coef_t'($signed({1'b0, src_row[3]})) - coef_t'($signed({1'b0, ref_row[3]}));
		rc = had4(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	// row coefficients stay within +-1020, so 11 bits hold them
	always_ff @(posedge clk) begin
		if (en) begin
			rowc_s1[0] <= rowc_t'(rc.c0);
			rowc_s1[1] <= rowc_t'(rc.c1);
			rowc_s1[2] <= rowc_t'(rc.c2);
			rowc_s1[3] <= rowc_t'(rc.c3);
		end
	end

endmodule

// File: sv/hsatd_lane.sv
// hsatd_lane: one coefficient column; holds rows 0..2 per segment, runs the column
// hadamard on row 3 and sums the four absolute values. depends on hsatd_pkg
module hsatd_lane import hsatd_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  ctrl_t ctrl_s1,
	input  rowc_t rowc_s1,
	output lsum_t lane_sum_s3
);

	rowc_t row0_q [4];
	rowc_t row1_q [4];
	rowc_t row2_q [4];
	absc_t abs_s2 [4];
	quad_t col;
	quad_t cc;

	always_ff @(posedge clk) begin
		if (en && ctrl_s1.valid && (ctrl_s1.row != LAST_ROW)) begin
			case (ctrl_s1.row)
				2'd0: row0_q[ctrl_s1.seg] <= rowc_s1;
				2'd1: row1_q[ctrl_s1.seg] <= rowc_s1;
				2'd2: row2_q[ctrl_s1.seg] <= rowc_s1;
				default: ;
			endcase
		end
	end

	// only meaningful for row 3 words; other rows are ignored downstream
	always_comb begin
		col.c0 = coef_t'(row0_q[ctrl_s1.seg]);
		col.c1 = coef_t'(row1_q[ctrl_s1.seg]);
		col.c2 = coef_t'(row2_q[ctrl_s1.seg]);
		col.c3 = coef_t'(rowc_s1);
		cc = had4(col);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abs_s2[0] <= abs_coef(cc.c0);
			abs_s2[1] <= abs_coef(cc.c1);
			abs_s2[2] <= abs_coef(cc.c2);
			abs_s2[3] <= abs_coef(cc.c3);
			lane_sum_s3 <= lsum_t'(abs_s2[0]) + lsum_t'(abs_s2[1])
				+ lsum_t'(abs_s2[2]) + lsum_t'(abs_s2[3]);
		end
	end

endmodule

// File: sv/hsatd_merge.sv
// hsatd_merge: adds the lane sums, pairs the two 4x4 halves of each 8x4, accumulates
// the block total and holds the result word. depends on hsatd_pkg
module hsatd_merge import hsatd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        clear,
	input  ctrl_t       ctrl_s3,
	input  lsum_t       lane_sum_s3 [NUM_LANES],
	input  logic        satd_ready,
	output logic        stall,
	output logic [18:0] satd,
	output logic        satd_valid
);

	ctrl_t       ctrl_s4;
	sub_t        sub_s4;
	sub_t        half_q [2];
	total_t      total_q;
	logic [18:0] satd_q;
	logic        satd_valid_q;
	sub_t        pair;
	total_t      total_new;
	logic        row3;

	always_comb begin
		pair      = half_q[ctrl_s4.seg[1]] + sub_s4;
		total_new = total_q + total_t'(pair >> 1);
		row3      = ctrl_s4.valid && (ctrl_s4.row == LAST_ROW);
		// hold everything only when a new result meets a full output register
		stall     = ctrl_s4.valid && ctrl_s4.last && satd_valid_q && !satd_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
		end else if (en) begin
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sub_s4 <= sub_t'(lane_sum_s3[0]) + sub_t'(lane_sum_s3[1])
				+ sub_t'(lane_sum_s3[2]) + sub_t'(lane_sum_s3[3]);
		end
	end

	// even segment opens a half sum, odd segment closes the 8x4 pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q[0] <= '0;
			half_q[1] <= '0;
			total_q   <= '0;
		end else if (clear) begin
			half_q[0] <= '0;
			half_q[1] <= '0;
			total_q   <= '0;
		end else if (en && row3) begin
			if (!ctrl_s4.seg[0]) begin
				half_q[ctrl_s4.seg[1]] <= sub_s4;
			end else if (ctrl_s4.last) begin
				total_q <= '0;
			end else begin
				total_q <= total_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			satd_valid_q <= 1'b0;
		end else if (en && ctrl_s4.valid && ctrl_s4.last) begin
			satd_valid_q <= 1'b1;
		end else if (satd_ready) begin
			satd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_s4.valid && ctrl_s4.last) begin
			satd_q <= total_new[18:0];
		end
	end

	assign satd       = satd_q;
	assign satd_valid = satd_valid_q;

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(satd_valid_q) |-> $past(ctrl_s4.valid && ctrl_s4.last))
		else $error("result word appeared without a last item");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		satd_valid_q |-> (satd_q <= SATD_MAX))
		else $error("satd above the largest possible block value");

endmodule

// File: sv/hadamard_satd_block.sv
// hadamard_satd_block: top level; position counter, mode register, control pipeline
// depends on hsatd_pkg, hsatd_row_xform, hsatd_lane, hsatd_merge
//
// Takes one word of four source and four reference pixels per cycle, in raster
// order, and returns one satd word per block: 8 words for an 8x4 block
// (block_mode 0) or 64 words for a 16x16 block (block_mode 1, reset value).
// A word is accepted every cycle; four column lanes run the column transform in
// parallel, so the only throughput limit is the output register: input stalls
// only while a finished result is still waiting and the next block's last word
// reaches the merge stage. The last word of a block passes the row, lane and merge
// stages before its result is registered. Writing block_mode abandons any block in
// progress; write it only while the block is idle.
module hadamard_satd_block import hsatd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        block_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_pix0,
	input  logic [7:0]  src_pix1,
	input  logic [7:0]  src_pix2,
	input  logic [7:0]  src_pix3,
	input  logic [7:0]  ref_pix0,
	input  logic [7:0]  ref_pix1,
	input  logic [7:0]  ref_pix2,
	input  logic [7:0]  ref_pix3,
	output logic        satd_valid,
	input  logic        satd_ready,
	output logic [18:0] satd
);

	logic            mode_q;
	logic [5:0]      pos_q;
	logic            en;
	logic            stall;
	logic            cfg_wr;
	logic            in_acc;
	ctrl_t           ctrl_in;
	ctrl_t           ctrl_s1;
	ctrl_t           ctrl_s2;
	ctrl_t           ctrl_s3;
	logic [3:0][7:0] src_row;
	logic [3:0][7:0] ref_row;
	rowc_t           rowc_s1 [NUM_LANES];
	lsum_t           lane_sum_s3 [NUM_LANES];

	assign en        = !stall;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;

	assign src_row = {src_pix3, src_pix2, src_pix1, src_pix0};
	assign ref_row = {ref_pix3, ref_pix2, ref_pix1, ref_pix0};

	always_comb begin
		ctrl_in.valid = in_acc;
		if (mode_q == MODE_16X16) begin
			ctrl_in.seg  = pos_q[1:0];
			ctrl_in.row  = pos_q[3:2];
			ctrl_in.last = (pos_q == LAST_POS_16);
		end else begin
			ctrl_in.seg  = {1'b0, pos_q[0]};
			ctrl_in.row  = pos_q[2:1];
			ctrl_in.last = (pos_q == LAST_POS_8);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_16X16;
			pos_q  <= '0;
		end else if (cfg_wr) begin
			mode_q <= block_mode;
			pos_q  <= '0;
		end else if (in_acc) begin
			pos_q <= ctrl_in.last ? 6'd0 : pos_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	hsatd_row_xform u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctrl_in (ctrl_in),
		.src_row (src_row),
		.ref_row (ref_row),
		.ctrl_s1 (ctrl_s1),
		.rowc_s1 (rowc_s1)
	);

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		hsatd_lane u_lane (
			.clk         (clk),
			.en          (en),
			.ctrl_s1     (ctrl_s1),
			.rowc_s1     (rowc_s1[k]),
			.lane_sum_s3 (lane_sum_s3[k])
		);
	end

	hsatd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.clear       (cfg_wr),
		.ctrl_s3     (ctrl_s3),
		.lane_sum_s3 (lane_sum_s3),
		.satd_ready  (satd_ready),
		.stall       (stall),
		.satd        (satd),
		.satd_valid  (satd_valid)
	);

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (pos_q == 6'd0))
		else $error("mode write did not restart the block");

	a_pos_8x4: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_8X4) |-> (pos_q <= LAST_POS_8))
		else $error("position ran past the end of an 8x4 block");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ctrl_in.last) |=> (pos_q == 6'd0))
		else $error("position did not wrap after the last word");

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench for hadamard_satd_block, 8x4 and 16x16 modes
// depends on hsatd_pkg and the hadamard_satd_block rtl; predicts every satd word itself
module tb_top;
	import hsatd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_ITEMS = 550;

	typedef struct packed {
		logic [3:0][7:0] src;
		logic [3:0][7:0] rpx;
	} pix_word_t;

	typedef enum int {
		PAT_RANDOM, PAT_EXTREME, PAT_SMALL, PAT_ZERO, PAT_MAXPOS, PAT_MAXNEG, PAT_CHECKER
	} pat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_mode = MODE_16X16;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_word_t cur_word = '0;
	logic satd_valid;
	logic satd_ready = 1'b0;
	logic [18:0] satd;

	pix_word_t pixel_words[$];
	logic [18:0] satd_expected[$];
	int mismatches = 0;
	int cycle_cnt = 0;
	int in_gap = 0;
	int stall_left = 0;
	bit in_fire = 1'b0;
	bit quiet = 1'b0;

	// predictor state
	logic pred_mode;
	logic signed [10:0] coeff_mem [48];
	logic [16:0] half_sum [2];
	logic [19:0] total_sum;
	logic [5:0] pos;

	hadamard_satd_block i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.block_mode (cfg_mode),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.src_pix0   (cur_word.src[0]),
		.src_pix1   (cur_word.src[1]),
		.src_pix2   (cur_word.src[2]),
		.src_pix3   (cur_word.src[3]),
		.ref_pix0   (cur_word.rpx[0]),
		.ref_pix1   (cur_word.rpx[1]),
		.ref_pix2   (cur_word.rpx[2]),
		.ref_pix3   (cur_word.rpx[3]),
		.satd_valid (satd_valid),
		.satd_ready (satd_ready),
		.satd       (satd)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void fwht4(input int a0, a1, a2, a3, output int d0, d1, d2, d3);
		int t0, t1, t2, t3;
		t0 = a0 + a1;
		t1 = a0 - a1;
		t2 = a2 + a3;
		t3 = a2 - a3;
		d0 = t0 + t2;
		d1 = t1 + t3;
		d2 = t0 - t2;
		d3 = t1 - t3;
	endfunction

	function automatic void clear_block();
		half_sum[0] = '0;
		half_sum[1] = '0;
		total_sum = '0;
		pos = '0;
	endfunction

	function automatic void set_block_mode(input logic m);
		pred_mode = m;
		clear_block();
	endfunction

	function automatic void predict_satd(input pix_word_t w);
		int diff[4];
		int rc[4];
		int col[4];
		int cc[4];
		int sub;
		int seg, row, half;
		logic [5:0] last_pos;
		if (pred_mode == MODE_16X16) begin
			seg = pos[1:0];
			row = pos[3:2];
			last_pos = LAST_POS_16;
		end else begin
			seg = pos[0];
			row = pos[2:1];
			last_pos = LAST_POS_8;
		end
		half = seg >> 1;
		for (int i = 0; i < 4; i++)
			diff[i] = int'(w.src[i]) - int'(w.rpx[i]);
		fwht4(diff[0], diff[1], diff[2], diff[3], rc[0], rc[1], rc[2], rc[3]);
		if (row < LAST_ROW) begin
			for (int k = 0; k < 4; k++)
				coeff_mem[row * 16 + seg * 4 + k] = rc[k][10:0];
		end else begin
			// fourth row of the sub-block: column transform over stored rows
			sub = 0;
			for (int k = 0; k < 4; k++) begin
				for (int r = 0; r < 3; r++)
					col[r] = coeff_mem[r * 16 + seg * 4 + k];
				col[3] = rc[k];
				fwht4(col[0], col[1], col[2], col[3], cc[0], cc[1], cc[2], cc[3]);
				for (int r = 0; r < 4; r++)
					sub += (cc[r] < 0) ? -cc[r] : cc[r];
			end
			half_sum[half] = half_sum[half] + sub[16:0];
			if (seg & 1) begin
				total_sum = total_sum + {4'b0, half_sum[half][16:1]};
				half_sum[half] = '0;
			end
		end
		if (pos == last_pos) begin
			satd_expected.push_back(total_sum[18:0]);
			clear_block();
		end else begin
			pos = pos + 6'd1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_word_t gen_word(input pat_t p, input int row);
		pix_word_t w;
		int v;
		for (int i = 0; i < 4; i++) begin
			case (p)
				PAT_EXTREME: begin
					w.src[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					w.rpx[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end
				PAT_SMALL: begin
					w.src[i] = $urandom_range(0, 255);
					v = int'(w.src[i]) + $urandom_range(0, 6) - 3;
					w.rpx[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
				end
				PAT_ZERO: begin
					w.src[i] = $urandom_range(0, 255);
					w.rpx[i] = w.src[i];
				end
				PAT_MAXPOS: begin
					w.src[i] = 8'd255;
					w.rpx[i] = 8'd0;
				end
				PAT_MAXNEG: begin
					w.src[i] = 8'd0;
					w.rpx[i] = 8'd255;
				end
				PAT_CHECKER: begin
					w.src[i] = ((i + row) & 1) ? 8'd255 : 8'd0;
					w.rpx[i] = ~w.src[i];
				end
				default: begin
					w.src[i] = $urandom_range(0, 255);
					w.rpx[i] = $urandom_range(0, 255);
				end
			endcase
		end
		return w;
	endfunction

	function automatic pat_t pick_pattern();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return PAT_RANDOM;
		if (r < 7)
			return PAT_EXTREME;
		if (r == 7)
			return PAT_SMALL;
		if (r == 8)
			return PAT_ZERO;
		return $urandom_range(0, 1) ? PAT_MAXPOS : PAT_MAXNEG;
	endfunction

	// driver: one pixel word at a time, random gaps between words outside quiet phases
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (in_gap != 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pixel_words.size() != 0) begin
				cur_word <= pixel_words.pop_front();
				in_valid <= 1'b1;
				in_gap <= quiet ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			satd_ready <= 1'b0;
		end else begin
			satd_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) < 3)
				stall_left <= pick_gap();
		end
	end

	// monitor: predict on every accepted word, check every accepted result
	always @(posedge clk) begin
		logic [18:0] want;
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			in_fire = in_valid && in_ready;
			if (cfg_valid && cfg_ready)
				set_block_mode(cfg_mode);
			if (in_fire)
				predict_satd(cur_word);
			if (satd_valid && satd_ready) begin
				if (satd_expected.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected satd word %0d at cycle %0d", satd, cycle_cnt);
					mismatches++;
				end else begin
					want = satd_expected.pop_front();
					if (satd !== want) begin
						if (mismatches < 10)
							$display("satd mismatch at cycle %0d: expected %0d, got %0d",
								cycle_cnt, want, satd);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_mode <= m;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every word is in and every result is out, then let the pipe settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_words.size() != 0 || in_valid || satd_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int sent;
		int per_blk;
		int nblk;
		logic m;
		pat_t p;
		pred_mode = MODE_16X16;
		clear_block();
		for (int i = 0; i < 48; i++)
			coeff_mem[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset mode is 16x16: eight words must not finish a block
		for (int n = 0; n < 8; n++)
			pixel_words.push_back(gen_word(PAT_MAXPOS, n));
		wait_idle();
		write_mode(MODE_8X4);
		for (int n = 0; n < 8; n++)
			pixel_words.push_back(gen_word(PAT_MAXNEG, n >> 1));
		for (int n = 0; n < 8; n++)
			pixel_words.push_back(gen_word(PAT_CHECKER, n >> 1));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			quiet = ($urandom_range(0, 3) == 0);
			m = ($urandom_range(0, 2) == 0) ? MODE_16X16 : MODE_8X4;
			if (m != pred_mode || $urandom_range(0, 2) != 0)
				write_mode(m);
			m = pred_mode;
			per_blk = (m == MODE_16X16) ? 64 : 8;
			nblk = (m == MODE_16X16) ? 1 : $urandom_range(1, 6);
			for (int b = 0; b < nblk; b++) begin
				p = pick_pattern();
				for (int n = 0; n < per_blk; n++) begin
					pixel_words.push_back(gen_word(p, (m == MODE_16X16) ? n >> 2 : n >> 1));
					sent++;
				end
			end
			// sometimes leave a block unfinished for the next phase or mode write
			if ($urandom_range(0, 5) == 0) begin
				nblk = $urandom_range(1, per_blk - 1);
				for (int n = 0; n < nblk; n++) begin
					pixel_words.push_back(gen_word(PAT_RANDOM, 0));
					sent++;
				end
			end
		end
		wait_idle();

		if (mismatches == 0 && satd_expected.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
